// ===== sv/efr_pkg.sv =====
// Package with shared types and constants for the escaped frame receiver.
`timescale 1ns / 1ps

package efr_pkg;

  // Default depth of the frame buffer that the write index walks through.
  localparam int unsigned DEFAULT_BUFFER_LENGTH = 256;

  // Bytes at or below this value are offset by the escape marker after an escape.
  localparam logic [7:0] ESC_RANGE_TOP = 8'd3;

  // Marker values after reset.
  localparam logic [7:0] START_MARKER_RST  = 8'd209;
  localparam logic [7:0] END_MARKER_RST    = 8'd210;
  localparam logic [7:0] ESCAPE_MARKER_RST = 8'd208;

  // Register word index on the configuration port (byte address / 4).
  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_END    = 2'd1,
    REG_ESCAPE = 2'd2
  } reg_idx_e;

  // Input kinds.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_REARM = 1'b1;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] escape_marker;
  } markers_t;

  typedef struct packed {
    logic done;
    logic esc;
    logic open;
    logic rx;
  } frame_flags_t;

  localparam frame_flags_t FLAGS_RST = '{done: 1'b0, esc: 1'b0, open: 1'b0, rx: 1'b1};

  typedef struct packed {
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       frame_done;
    logic       receiving;
  } result_t;

endpackage

// ===== sv/escaped_frame_receiver_top.sv =====
// Top level of the escaped frame receiver: stream ports, marker registers and result register.
`timescale 1ns / 1ps
// A result appears on the master side in the cycle after its input transaction is accepted.
// One transaction per cycle unless the master stalls; the result register is the only stage.
// The input side stays ready while the result register is empty or being drained.
// Reset (rst_ni low, asynchronous) empties the result register, enables reception,
// closes any frame, clears the escape and write index, and restores the marker values.

module escaped_frame_receiver_top
  import efr_pkg::*;
#(
  parameter int unsigned BufferLength = DEFAULT_BUFFER_LENGTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Received bytes and rearm requests.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] kind (0 byte, 1 rearm)

  // One result per input transaction.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] store_index, [15:8] store_byte,
                                      // [16] receiving, [23:17] zero
  output logic        m_axis_tuser,   // [0] store_valid
  output logic        m_axis_tlast,   // frame_done

  // Marker configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = $clog2(BufferLength);

  markers_t          markers_q;
  frame_flags_t      flags_q, flags_d;
  logic [IdxW-1:0]   wr_idx_q, wr_idx_d;
  result_t           result_q, result_d;
  logic              out_valid_q;
  logic              in_accept;
  logic              cfg_write;
  reg_idx_e          reg_sel;

  // The configuration port never waits.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      markers_q.start_marker  <= START_MARKER_RST;
      markers_q.end_marker    <= END_MARKER_RST;
      markers_q.escape_marker <= ESCAPE_MARKER_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_START:  markers_q.start_marker  <= pwdata[7:0];
        REG_END:    markers_q.end_marker    <= pwdata[7:0];
        REG_ESCAPE: markers_q.escape_marker <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START:  prdata = {24'd0, markers_q.start_marker};
      REG_END:    prdata = {24'd0, markers_q.end_marker};
      REG_ESCAPE: prdata = {24'd0, markers_q.escape_marker};
      default:    prdata = 32'd0;
    endcase
  end

  // A new transaction is taken whenever the result register is free or is being
  // read in the same cycle, so the stream runs at one item per clock while the master keeps up.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  efr_step #(
    .BufferLength(BufferLength)
  ) u_step (
    .kind_i    (s_axis_tuser),
    .rx_byte_i (s_axis_tdata),
    .markers_i (markers_q),
    .flags_i   (flags_q),
    .wr_idx_i  (wr_idx_q),
    .flags_o   (flags_d),
    .wr_idx_o  (wr_idx_d),
    .result_o  (result_d)
  );

  // Deframer state advances only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= FLAGS_RST;
      wr_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        flags_q     <= flags_d;
        wr_idx_q    <= wr_idx_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload is held while the master side stalls.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, result_q.receiving, result_q.store_byte, result_q.store_index};
  assign m_axis_tuser  = result_q.store_valid;
  assign m_axis_tlast  = result_q.frame_done;

endmodule

// ===== sv/efr_step.sv =====
// Combinational deframing step: next flags, next write index and the result for one item.
`timescale 1ns / 1ps

module efr_step
  import efr_pkg::*;
#(
  parameter int unsigned BufferLength = DEFAULT_BUFFER_LENGTH,
  localparam int unsigned IdxW = $clog2(BufferLength)
) (
  input  logic              kind_i,
  input  logic [7:0]        rx_byte_i,
  input  markers_t          markers_i,
  input  frame_flags_t      flags_i,
  input  logic [IdxW-1:0]   wr_idx_i,
  output frame_flags_t      flags_o,
  output logic [IdxW-1:0]   wr_idx_o,
  output result_t           result_o
);

  logic [7:0] idx8;
  logic       is_start;
  logic       is_escape;
  logic       is_end;

  // The reported index is the low byte of the write index.
  if (IdxW >= 8) begin : g_idx_wide
    assign idx8 = wr_idx_i[7:0];
  end else begin : g_idx_narrow
    assign idx8 = {{(8 - IdxW){1'b0}}, wr_idx_i};
  end

  assign is_start  = (rx_byte_i == markers_i.start_marker);
  assign is_escape = (rx_byte_i == markers_i.escape_marker);
  assign is_end    = (rx_byte_i == markers_i.end_marker);

  always_comb begin
    flags_o  = flags_i;
    wr_idx_o = wr_idx_i;
    result_o = '0;
    if (kind_i == KIND_REARM) begin
      flags_o.rx   = 1'b1;
      flags_o.done = 1'b0;
    end else if (flags_i.rx) begin
      // Marker checks run in the order start, escape, end.
      priority if (is_start) begin
        wr_idx_o     = '0;
        flags_o.open = 1'b1;
      end else if (is_escape) begin
        flags_o.esc = 1'b1;
      end else begin
        if (is_end && flags_i.open) begin
          flags_o.done        = 1'b1;
          flags_o.open        = 1'b0;
          flags_o.rx          = 1'b0;
          result_o.frame_done = 1'b1;
        end
        if (flags_i.esc && (rx_byte_i <= ESC_RANGE_TOP)) begin
          result_o.store_byte = rx_byte_i + markers_i.escape_marker;
        end else begin
          result_o.store_byte = rx_byte_i;
        end
        result_o.store_valid = 1'b1;
        result_o.store_index = idx8;
        if (wr_idx_i == IdxW'(BufferLength - 1)) begin
          wr_idx_o = '0;
        end else begin
          wr_idx_o = wr_idx_i + IdxW'(1);
        end
        flags_o.esc = 1'b0;
      end
    end
    result_o.receiving = flags_o.rx;
  end

endmodule

// ===== sv/efr_checker.sv =====
// Port-level checks for the escaped frame receiver, bound to its top level.
`timescale 1ns / 1ps

module efr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // A completed frame always comes with a store of the end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("frame done without a store");

  // Completing a frame turns reception off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[16])
    else $error("reception still enabled after frame done");

  // Results without a store carry zero index and byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0)
    else $error("nonzero index or byte without a store");

  // A draining output never blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

endmodule

bind escaped_frame_receiver_top efr_checker u_efr_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the escaped frame receiver, driven through its stream and APB ports.
`timescale 1ns / 1ps

// The bench sends received bytes and rearm requests on the slave stream and collects one
// result per input transaction from the master stream. A predictor follows the frame
// flags, the write index and the marker registers, and every result is compared field by
// field with the oldest expectation. A short directed list comes first. Then a long frame
// runs the write index past its wrap point, and random traffic follows under several
// marker settings. Most of that traffic is well-formed frames: start, payload with
// escapes, end and rearm. The remainder is loose bytes and rearm requests.
module tb_top;
  import efr_pkg::*;

  localparam int unsigned BUF_LEN        = DEFAULT_BUFFER_LENGTH;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          PHASE_ITEMS    = 45;
  localparam int          LONG_FRAME_LEN = 270;

  // One row of the directed list. When typed is set, value is the result that the row
  // must produce; otherwise the predictor supplies it.
  typedef struct {
    logic       kind;
    logic [7:0] data;
    bit         typed;
    result_t    value;
  } stim_row_t;

  typedef struct {
    bit      typed;
    result_t value;
  } typed_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        s_axis_tuser;   // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] store_index, [15:8] store_byte, [16] receiving
  logic        m_axis_tuser;   // [0] store_valid
  logic        m_axis_tlast;   // frame_done
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: its own copy of the marker registers, the flags and the index.
  markers_t     marker_cfg = '{START_MARKER_RST, END_MARKER_RST, ESCAPE_MARKER_RST};
  frame_flags_t rx_state   = FLAGS_RST;
  int unsigned  write_pos  = 0;

  result_t       expected_results[$];
  typed_result_t typed_results[$];
  stim_row_t     directed_rows[$];

  int  error_count    = 0;
  int  results_seen   = 0;
  int  frames_closed  = 0;
  int  buffer_writes  = 0;
  int  settings_used  = 1;
  int  quiet_cycles   = 0;
  bit  send_burst     = 1'b0;
  bit  recv_burst     = 1'b0;

  escaped_frame_receiver_top #(
    .BufferLength(BUF_LEN)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  // Advances the predictor by one input transaction and returns the result it causes.
  function automatic result_t deframe_step(logic kind, logic [7:0] b);
    result_t r;
    r = '0;
    if (kind == KIND_REARM) begin
      rx_state.rx   = 1'b1;
      rx_state.done = 1'b0;
    end else if (rx_state.rx) begin
      // Start wins over escape, and escape wins over end, when markers share a value.
      if (b == marker_cfg.start_marker) begin
        write_pos     = 0;
        rx_state.open = 1'b1;
      end else if (b == marker_cfg.escape_marker) begin
        rx_state.esc = 1'b1;
      end else begin
        if (b == marker_cfg.end_marker && rx_state.open) begin
          rx_state.done = 1'b1;
          rx_state.open = 1'b0;
          rx_state.rx   = 1'b0;
          r.frame_done  = 1'b1;
        end
        r.store_byte  = (rx_state.esc && b <= ESC_RANGE_TOP) ? b + marker_cfg.escape_marker : b;
        r.store_valid = 1'b1;
        r.store_index = write_pos[7:0];
        write_pos     = (write_pos + 1) % BUF_LEN;
        rx_state.esc  = 1'b0;
      end
    end
    r.receiving = rx_state.rx;
    return r;
  endfunction

  function automatic result_t res(bit v, logic [7:0] idx, logic [7:0] b, bit done, bit rx);
    result_t r;
    r.store_valid = v;
    r.store_index = idx;
    r.store_byte  = b;
    r.frame_done  = done;
    r.receiving   = rx;
    return r;
  endfunction

  function automatic stim_row_t row(logic kind, logic [7:0] data, bit typed, result_t value);
    stim_row_t s;
    s.kind  = kind;
    s.data  = data;
    s.typed = typed;
    s.value = value;
    return s;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Biased byte for loose traffic: markers and the escape range come up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return marker_cfg.start_marker;
      1:       return marker_cfg.end_marker;
      2:       return marker_cfg.escape_marker;
      3:       return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A payload byte that matches none of the markers.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == marker_cfg.start_marker || b == marker_cfg.end_marker ||
               b == marker_cfg.escape_marker);
    return b;
  endfunction

  // Scoreboard: checks master-side transactions, predicts on slave-side transactions,
  // tracks register writes and runs the watchdog.
  always @(posedge clk_i) begin : scoreboard
    result_t       got;
    result_t       want;
    typed_result_t tr;
    if (rst_ni) begin
      quiet_cycles = quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        got.store_valid = m_axis_tuser;
        got.store_index = m_axis_tdata[7:0];
        got.store_byte  = m_axis_tdata[15:8];
        got.frame_done  = m_axis_tlast;
        got.receiving   = m_axis_tdata[16];
        if (expected_results.size() == 0) begin
          $error("Result transaction arrived with no expectation waiting");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("store_valid", want.store_valid, got.store_valid);
          check_field("store_index", want.store_index, got.store_index);
          check_field("store_byte", want.store_byte, got.store_byte);
          check_field("frame_done", want.frame_done, got.frame_done);
          check_field("receiving", want.receiving, got.receiving);
        end
        results_seen++;
        if (got.frame_done) frames_closed++;
        if (got.store_valid) buffer_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        quiet_cycles = 0;
        tr = typed_results.pop_front();
        want = deframe_step(s_axis_tuser, s_axis_tdata);
        if (tr.typed) want = tr.value;
        expected_results.push_back(want);
      end
      if (psel && penable && pready) begin
        quiet_cycles = 0;
        if (pwrite) begin
          case (reg_idx_e'(paddr[3:2]))
            REG_START:  marker_cfg.start_marker  = pwdata[7:0];
            REG_END:    marker_cfg.end_marker    = pwdata[7:0];
            REG_ESCAPE: marker_cfg.escape_marker = pwdata[7:0];
            default:    ;
          endcase
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results still expected",
                 quiet_cycles, expected_results.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: inserts a random stall, possibly none, before each transaction, with stretches
  // of back-to-back acceptance.
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Sends one input transaction after a random gap and returns at the accepting edge.
  task automatic send_item(logic kind, logic [7:0] b, bit typed, result_t value);
    int gap;
    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    typed_results.push_back('{typed, value});
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Lowers the slave valid and waits until every expected result has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes one marker register and reads it back. The task leaves psel high; the caller
  // closes the bus after its last access.
  task automatic write_marker(reg_idx_e idx, logic [7:0] value);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    if (rd !== {24'h0, value}) begin
      $error("Readback of register %s: expected 'h%0h, got 'h%0h", idx.name(), value, rd);
      error_count++;
    end
  endtask

  task automatic set_markers(logic [7:0] start_v, logic [7:0] end_v, logic [7:0] esc_v);
    write_marker(REG_START, start_v);
    write_marker(REG_END, end_v);
    write_marker(REG_ESCAPE, esc_v);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  // Mostly complete frames with random payload and escapes; the rest is loose traffic.
  // The stray bytes sent after each frame's end are not counted against the budget.
  task automatic random_traffic(int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        send_item(KIND_BYTE, marker_cfg.start_marker, 1'b0, '0);
        len = $urandom_range(0, 12);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) begin
            send_item(KIND_BYTE, marker_cfg.escape_marker, 1'b0, '0);
            send_item(KIND_BYTE, $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                     : 8'($urandom_range(0, 255)), 1'b0, '0);
            sent += 2;
          end else begin
            send_item(KIND_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
            sent++;
          end
        end
        // Some frames are left unterminated, so the next start marker has to recover.
        if ($urandom_range(0, 5) != 0) begin
          send_item(KIND_BYTE, marker_cfg.end_marker, 1'b0, '0);
          sent++;
        end
        repeat ($urandom_range(0, 2)) send_item(KIND_BYTE, pick_byte(), 1'b0, '0);
        send_item(KIND_REARM, 8'($urandom_range(0, 255)), 1'b0, '0);
        sent += 2;
      end else begin
        send_item(($urandom_range(0, 7) == 0) ? KIND_REARM : KIND_BYTE, pick_byte(), 1'b0, '0);
        sent++;
      end
    end
    drain();
  endtask

  initial begin : stimulus
    // Directed list under the reset markers: stores outside a frame, a rearm while
    // already enabled, each escape value at the edges of the escape range, a start and a
    // second escape while an escape is armed, closing the frame, bytes ignored while
    // reception is off, and an end marker with no frame open.
    directed_rows.push_back(row(KIND_BYTE, 8'h00, 1'b1,
                                res(1'b1, 8'd0, 8'h00, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, 8'hFF, 1'b1,
                                res(1'b1, 8'd1, 8'hFF, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, END_MARKER_RST, 1'b1,
                                res(1'b1, 8'd2, END_MARKER_RST, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_REARM, 8'hA5, 1'b1,
                                res(1'b0, 8'd0, 8'h00, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, START_MARKER_RST, 1'b1,
                                res(1'b0, 8'd0, 8'h00, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, ESCAPE_MARKER_RST, 1'b1,
                                res(1'b0, 8'd0, 8'h00, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, 8'h00, 1'b1,
                                res(1'b1, 8'd0, 8'hD0, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, ESCAPE_MARKER_RST, 1'b0, '0));
    directed_rows.push_back(row(KIND_BYTE, 8'h03, 1'b1,
                                res(1'b1, 8'd1, 8'hD3, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, ESCAPE_MARKER_RST, 1'b0, '0));
    directed_rows.push_back(row(KIND_BYTE, 8'h04, 1'b1,
                                res(1'b1, 8'd2, 8'h04, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, ESCAPE_MARKER_RST, 1'b0, '0));
    directed_rows.push_back(row(KIND_BYTE, START_MARKER_RST, 1'b0, '0));
    directed_rows.push_back(row(KIND_BYTE, 8'h02, 1'b1,
                                res(1'b1, 8'd0, 8'hD2, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, ESCAPE_MARKER_RST, 1'b0, '0));
    directed_rows.push_back(row(KIND_BYTE, ESCAPE_MARKER_RST, 1'b0, '0));
    directed_rows.push_back(row(KIND_BYTE, 8'h01, 1'b1,
                                res(1'b1, 8'd1, 8'hD1, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, 8'h80, 1'b0, '0));
    directed_rows.push_back(row(KIND_BYTE, END_MARKER_RST, 1'b1,
                                res(1'b1, 8'd3, END_MARKER_RST, 1'b1, 1'b0)));
    directed_rows.push_back(row(KIND_BYTE, 8'h55, 1'b1,
                                res(1'b0, 8'd0, 8'h00, 1'b0, 1'b0)));
    directed_rows.push_back(row(KIND_BYTE, START_MARKER_RST, 1'b1,
                                res(1'b0, 8'd0, 8'h00, 1'b0, 1'b0)));
    directed_rows.push_back(row(KIND_REARM, 8'h00, 1'b1,
                                res(1'b0, 8'd0, 8'h00, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, 8'h7F, 1'b1,
                                res(1'b1, 8'd4, 8'h7F, 1'b0, 1'b1)));
    directed_rows.push_back(row(KIND_BYTE, ESCAPE_MARKER_RST, 1'b0, '0));
    directed_rows.push_back(row(KIND_BYTE, END_MARKER_RST, 1'b0, '0));

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_BYTE;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].typed,
                directed_rows[i].value);
    end

    // One long frame carries the write index through all eight bits and past the wrap.
    send_item(KIND_BYTE, marker_cfg.start_marker, 1'b0, '0);
    repeat (LONG_FRAME_LEN) send_item(KIND_BYTE, plain_byte(), 1'b0, '0);
    send_item(KIND_BYTE, marker_cfg.end_marker, 1'b0, '0);
    send_item(KIND_REARM, 8'h00, 1'b0, '0);
    random_traffic(PHASE_ITEMS);

    // Extreme values, an escape marker near the top so escaped values wrap, start and escape
    // shared, all three shared, markers inside the escape range, end and escape shared, and
    // one random setting.
    set_markers(8'h00, 8'hFF, 8'hFE);
    random_traffic(PHASE_ITEMS);
    set_markers(8'hFF, 8'h00, 8'hFF);
    random_traffic(PHASE_ITEMS);
    set_markers(8'h7E, 8'h7E, 8'h7E);
    random_traffic(PHASE_ITEMS);
    set_markers(8'h01, 8'h03, 8'h02);
    random_traffic(PHASE_ITEMS);
    set_markers(8'h7E, 8'h7D, 8'h7D);
    random_traffic(PHASE_ITEMS);
    set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    random_traffic(PHASE_ITEMS);

    repeat (3) @(posedge clk_i);
    $display("Summary: %0d result transactions checked under %0d marker settings.",
             results_seen, settings_used);
    $display("Summary: %0d buffer writes, %0d frames closed, %0d mismatches.",
             buffer_writes, frames_closed, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
